// ----- design/tlv_message_deframer_macros.svh -----
// Assertion macros shared by the deframer RTL.
// Included by modules that carry concurrent checks; needs no package.
`ifndef TLV_MESSAGE_DEFRAMER_MACROS_SVH
`define TLV_MESSAGE_DEFRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TLVD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define TLVD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/tlvd_pkg.sv -----
// Types and constants of the TLV message deframer.
// No dependencies; imported by tlvd_rsp_if and every module.
`timescale 1ns / 1ps
package tlvd_pkg;

   localparam int SIZE_MSG_LEN = 8;
   localparam int ACC_W        = 64;
   localparam int FILE_SIZE_W  = ACC_W - 1;
   localparam int POS_W        = 17;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 8;

   localparam logic [2:0] SIZE_LAST_FRAG = 3'(SIZE_MSG_LEN - 1);

   localparam logic [7:0] RST_CODE_FILE_DATA = 8'd0;
   localparam logic [7:0] RST_CODE_FILE_NAME = 8'd1;
   localparam logic [7:0] RST_CODE_FILE_SIZE = 8'd2;
   localparam logic [7:0] RST_CODE_CHAT      = 8'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CODE_FILE_DATA = 2'd0,
      CSR_CODE_FILE_NAME = 2'd1,
      CSR_CODE_FILE_SIZE = 2'd2,
      CSR_CODE_CHAT      = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_TYPE   = 3'd0,
      PH_LEN_HI = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_CHAT   = 3'd3,
      PH_DATA   = 3'd4,
      PH_NAME   = 3'd5,
      PH_SIZE   = 3'd6,
      PH_ERROR  = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      K_HEADER = 3'd0,
      K_CHAT   = 3'd1,
      K_DATA   = 3'd2,
      K_NAME   = 3'd3,
      K_SIZE   = 3'd4,
      K_ERROR  = 3'd5
   } kind_type;

   typedef struct packed {
      logic [7:0] code_file_data;
      logic [7:0] code_file_name;
      logic [7:0] code_file_size;
      logic [7:0] code_chat;
   } cfg_type;

   typedef struct packed {
      kind_type               kind;
      logic [7:0]             data_out;
      logic                   message_end;
      logic                   file_complete;
      logic                   size_ready;
      logic [FILE_SIZE_W-1:0] file_size_out;
      logic                   name_overflow;
      logic                   error;
   } result_type;

endpackage

// ----- design/tlvd_ifs.sv -----
// Stream channel interfaces of the deframer: byte request and result response.
// Depends on tlvd_pkg for field widths.
`timescale 1ns / 1ps
interface tlvd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_in;

   modport source (output valid, output byte_in, input ready);
   modport sink   (input valid, input byte_in, output ready);
endinterface

interface tlvd_rsp_if import tlvd_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [2:0]             kind;
   logic [7:0]             data_out;
   logic                   message_end;
   logic                   file_complete;
   logic                   size_ready;
   logic [FILE_SIZE_W-1:0] file_size_out;
   logic                   name_overflow;
   logic                   error;

   modport source (
      output valid, output kind, output data_out, output message_end,
      output file_complete, output size_ready, output file_size_out,
      output name_overflow, output error, input ready
   );
   modport sink (
      input valid, input kind, input data_out, input message_end,
      input file_complete, input size_ready, input file_size_out,
      input name_overflow, input error, output ready
   );
endinterface

// ----- design/tlvd_cfg_regs.sv -----
// Type code registers of the deframer, written through a plain write port.
// Depends on tlvd_pkg.
`timescale 1ns / 1ps
module tlvd_cfg_regs import tlvd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_CODE_FILE_DATA: cfg_in.code_file_data = csr_wdata;
            CSR_CODE_FILE_NAME: cfg_in.code_file_name = csr_wdata;
            CSR_CODE_FILE_SIZE: cfg_in.code_file_size = csr_wdata;
            CSR_CODE_CHAT:      cfg_in.code_chat      = csr_wdata;
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_file_data <= RST_CODE_FILE_DATA;
         cfg_ff.code_file_name <= RST_CODE_FILE_NAME;
         cfg_ff.code_file_size <= RST_CODE_FILE_SIZE;
         cfg_ff.code_chat      <= RST_CODE_CHAT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- design/tlvd_core.sv -----
// Parser state machine and datapath: one byte in, one result out, per step.
// Depends on tlvd_pkg and tlv_message_deframer_macros.svh.
`timescale 1ns / 1ps
`include "tlv_message_deframer_macros.svh"
module tlvd_core import tlvd_pkg::*; #(
   parameter int NAME_MAX_CHARS = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] byte_in,
   input  cfg_type    cfg,
   output result_type res
);

   localparam logic [POS_W-1:0] NAME_LIMIT = POS_W'(NAME_MAX_CHARS);

   phase_type        phase_ff,        phase_in;
   logic [7:0]       msg_type_ff,     msg_type_in;
   logic [15:0]      msg_length_ff,   msg_length_in;
   logic [POS_W-1:0] msg_position_ff, msg_position_in;
   logic [ACC_W-1:0] size_acc_ff,     size_acc_in;
   logic [2:0]       size_frag_ff,    size_frag_in;
   logic [ACC_W-1:0] bytes_total_ff,  bytes_total_in;

   logic [15:0]      len_full;
   logic             len_zero;
   logic             hit_data, hit_name, hit_size, hit_chat;
   logic [POS_W-1:0] pos_inc;
   logic             pos_last;
   logic [ACC_W-1:0] total_inc;
   logic             file_done;
   logic             frag_last;
   logic [ACC_W-1:0] acc_new;

   assign len_full  = {msg_length_ff[15:8], byte_in};
   assign len_zero  = (len_full == 16'd0);
   assign hit_data  = (msg_type_ff == cfg.code_file_data);
   assign hit_name  = (msg_type_ff == cfg.code_file_name);
   assign hit_size  = (msg_type_ff == cfg.code_file_size);
   assign hit_chat  = (msg_type_ff == cfg.code_chat);
   assign pos_inc   = msg_position_ff + POS_W'(1);
   assign pos_last  = (pos_inc >= {1'b0, msg_length_ff});
   assign total_inc = bytes_total_ff + ACC_W'(1);
   // a size with the top bit set completes on the first data byte
   assign file_done = size_acc_ff[ACC_W-1] | (total_inc >= size_acc_ff);
   assign frag_last = (size_frag_ff == SIZE_LAST_FRAG);

   // drop the byte into its big-endian lane; the first fragment starts clean
   always_comb begin
      acc_new = (size_frag_ff == 3'd0) ? '0 : size_acc_ff;
      for (int i = 0; i < SIZE_MSG_LEN; i++) begin
         if (size_frag_ff == 3'(i)) begin
            acc_new[ACC_W-1-8*i -: 8] = acc_new[ACC_W-1-8*i -: 8] | byte_in;
         end
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_TYPE:   phase_in = PH_LEN_HI;
         PH_LEN_HI: phase_in = PH_LEN_LO;
         PH_LEN_LO: begin
            priority if (hit_data) begin
               phase_in = len_zero ? PH_TYPE : PH_DATA;
            end else if (hit_name) begin
               phase_in = len_zero ? PH_TYPE : PH_NAME;
            end else if (hit_size) begin
               phase_in = (len_full == 16'(SIZE_MSG_LEN)) ? PH_SIZE : PH_ERROR;
            end else if (hit_chat) begin
               phase_in = len_zero ? PH_TYPE : PH_CHAT;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_CHAT, PH_NAME: begin
            if (pos_last) phase_in = PH_TYPE;
         end
         PH_SIZE: begin
            if (frag_last) phase_in = PH_TYPE;
         end
         PH_DATA: begin
            if (file_done || pos_last) phase_in = PH_TYPE;
         end
         PH_ERROR: phase_in = PH_ERROR;
         default:  phase_in = PH_ERROR;
      endcase
   end

   // result and datapath updates
   always_comb begin
      res             = '0;
      res.kind        = K_HEADER;
      msg_type_in     = msg_type_ff;
      msg_length_in   = msg_length_ff;
      msg_position_in = msg_position_ff;
      size_acc_in     = size_acc_ff;
      size_frag_in    = size_frag_ff;
      bytes_total_in  = bytes_total_ff;
      unique case (phase_ff)
         PH_TYPE: begin
            msg_type_in     = byte_in;
            msg_position_in = '0;
         end
         PH_LEN_HI: begin
            msg_length_in = {byte_in, 8'h00};
         end
         PH_LEN_LO: begin
            msg_length_in   = len_full;
            msg_position_in = '0;
            if (phase_in == PH_SIZE) size_frag_in = '0;
            res.message_end = (phase_in == PH_TYPE);
         end
         PH_CHAT: begin
            res.kind        = K_CHAT;
            res.data_out    = byte_in;
            msg_position_in = pos_inc;
            res.message_end = pos_last;
         end
         PH_NAME: begin
            res.kind = K_NAME;
            if (msg_position_ff < NAME_LIMIT) begin
               res.data_out = byte_in;
            end else begin
               res.name_overflow = 1'b1;
            end
            msg_position_in = pos_inc;
            res.message_end = pos_last;
         end
         PH_SIZE: begin
            res.kind        = K_SIZE;
            res.data_out    = byte_in;
            size_acc_in     = acc_new;
            size_frag_in    = size_frag_ff + 3'd1;
            msg_position_in = pos_inc;
            if (frag_last) begin
               res.size_ready    = 1'b1;
               res.file_size_out = acc_new[FILE_SIZE_W-1:0];
               res.message_end   = 1'b1;
            end
         end
         PH_DATA: begin
            res.kind           = K_DATA;
            res.data_out       = byte_in;
            msg_position_in    = pos_inc;
            bytes_total_in     = file_done ? '0 : total_inc;
            res.file_complete  = file_done;
            res.message_end    = file_done | pos_last;
         end
         PH_ERROR: begin
         end
         default: begin
         end
      endcase
      if (phase_in == PH_ERROR) begin
         res       = '0;
         res.kind  = K_ERROR;
         res.error = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_TYPE;
         msg_type_ff     <= '0;
         msg_length_ff   <= '0;
         msg_position_ff <= '0;
         size_acc_ff     <= '0;
         size_frag_ff    <= '0;
         bytes_total_ff  <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         msg_type_ff     <= msg_type_in;
         msg_length_ff   <= msg_length_in;
         msg_position_ff <= msg_position_in;
         size_acc_ff     <= size_acc_in;
         size_frag_ff    <= size_frag_in;
         bytes_total_ff  <= bytes_total_in;
      end
   end

   `TLVD_ASSERT_NEXT(a_error_sticky, clock, reset, phase_ff == PH_ERROR, phase_ff == PH_ERROR, "error state left without reset")
   `TLVD_ASSERT_NEXT(a_type_to_len, clock, reset, step && phase_ff == PH_TYPE, phase_ff == PH_LEN_HI && msg_position_ff == '0, "type byte did not start a header")
   `TLVD_ASSERT_NEXT(a_complete_clears, clock, reset, step && res.file_complete, bytes_total_ff == '0 && phase_ff == PH_TYPE, "file completion did not clear count")
   `TLVD_ASSERT_NEXT(a_size_wraps, clock, reset, step && res.size_ready, size_frag_ff == 3'd0 && phase_ff == PH_TYPE, "size assembly did not wrap")

endmodule

// ----- design/tlv_message_deframer.sv -----
// Top level of the TLV message deframer: input register, parser core, result register.
// Depends on tlvd_pkg, tlvd_ifs, tlvd_cfg_regs and tlvd_core.
`timescale 1ns / 1ps
// Takes one received byte per clock on req_chan while rsp_chan is ready, and returns
// exactly one result per byte on rsp_chan. Every byte passes an input register, is parsed
// by one level of logic against the message state, and lands in a result register, from
// which rsp_chan is offered the result; a new byte can be accepted while the last one
// waits there. The only limit on throughput is rsp_chan.ready, and req_chan.ready
// follows it within the same cycle once both registers are full. The per-byte cost is
// set by the 64-bit file byte count, incremented and compared with the announced size
// on each data byte. Type codes must be written on the csr_ port only while no byte is
// in flight; the user is bound by this, the block does not enforce it. An unknown type
// or a size message whose length is not 8 locks the block in an error state until reset.
module tlv_message_deframer import tlvd_pkg::*; #(
   parameter int NAME_MAX_CHARS = 255
) (
   input  logic                   clock,
   input  logic                   reset,
   tlvd_req_if.sink               req_chan,
   tlvd_rsp_if.source             rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type core_res;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff, out_valid_in;
   result_type out_res_ff;

   logic       accept;
   logic       advance;

   // move the held byte into the result register when that register frees up
   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) in_byte_ff <= req_chan.byte_in;
      if (advance) out_res_ff <= core_res;
   end

   tlvd_cfg_regs u_cfg_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   tlvd_core #(
      .NAME_MAX_CHARS (NAME_MAX_CHARS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .byte_in (in_byte_ff),
      .cfg     (cfg),
      .res     (core_res)
   );

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.kind          = out_res_ff.kind;
   assign rsp_chan.data_out      = out_res_ff.data_out;
   assign rsp_chan.message_end   = out_res_ff.message_end;
   assign rsp_chan.file_complete = out_res_ff.file_complete;
   assign rsp_chan.size_ready    = out_res_ff.size_ready;
   assign rsp_chan.file_size_out = out_res_ff.file_size_out;
   assign rsp_chan.name_overflow = out_res_ff.name_overflow;
   assign rsp_chan.error         = out_res_ff.error;

endmodule

// ----- tb/tlv_message_deframer_tb.sv -----
// Self-checking testbench of the TLV message deframer: framed byte streams in, per-byte results out.
// Depends on tlvd_pkg, the tlvd_req_if / tlvd_rsp_if interfaces and tlv_message_deframer.
`timescale 1ns / 1ps
module tlv_message_deframer_tb;
   import tlvd_pkg::*;

   localparam int NAME_LIMIT  = 255;
   localparam int LONG_HOLD   = 250;
   localparam int CYCLE_LIMIT = 500000;

   logic clock;
   logic reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   tlvd_req_if req_if ();
   tlvd_rsp_if rsp_if ();

   tlv_message_deframer #(.NAME_MAX_CHARS(NAME_LIMIT)) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // Type codes as currently programmed, shared by the stream builder and the predictor.
   cfg_type cfg;

   // Predicted deframer state.
   phase_type   dfr_phase;
   logic [7:0]  dfr_type;
   logic [15:0] dfr_len;
   logic [16:0] dfr_pos;
   logic [63:0] dfr_acc;
   logic [3:0]  dfr_frag;
   logic [63:0] dfr_total;
   logic        dfr_err;

   // Stream builder's view of the announced size and the file byte count.
   logic [63:0] gen_size;
   logic [63:0] gen_count;

   logic [7:0] pending_bytes[$];
   result_type expected_results[$];
   int         phase_pushed;

   bit  idle_on;
   int  gap_left;
   int  rsp_wait;
   int  hold_left;
   int  hold_req;
   int  hold_done;
   logic req_fire;
   logic rsp_fire;

   int  mismatch_count;
   int  cycle_count;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic kind_type meaning_of(input logic [7:0] t);
      if (t == cfg.code_file_data) return K_DATA;
      else if (t == cfg.code_file_name) return K_NAME;
      else if (t == cfg.code_file_size) return K_SIZE;
      else if (t == cfg.code_chat) return K_CHAT;
      return K_ERROR;
   endfunction

   task automatic deframe_byte(input logic [7:0] b, output result_type r);
      logic to_error;
      r = '0;
      to_error = 1'b0;
      case (dfr_phase)
         PH_TYPE: begin
            dfr_type = b;
            dfr_pos = '0;
            dfr_phase = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            dfr_len = {b, 8'h00};
            dfr_phase = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            dfr_len[7:0] = b;
            dfr_pos = '0;
            if (dfr_type == cfg.code_file_data) begin
               if (dfr_len != 0) dfr_phase = PH_DATA;
               else dfr_phase = PH_TYPE;
            end else if (dfr_type == cfg.code_file_name) begin
               if (dfr_len != 0) dfr_phase = PH_NAME;
               else dfr_phase = PH_TYPE;
            end else if (dfr_type == cfg.code_file_size) begin
               if (dfr_len != 16'(SIZE_MSG_LEN)) begin
                  to_error = 1'b1;
               end else begin
                  dfr_phase = PH_SIZE;
                  dfr_frag = '0;
               end
            end else if (dfr_type == cfg.code_chat) begin
               if (dfr_len != 0) dfr_phase = PH_CHAT;
               else dfr_phase = PH_TYPE;
            end else begin
               to_error = 1'b1;
            end
            if (!to_error && dfr_phase == PH_TYPE) r.message_end = 1'b1;
         end
         PH_CHAT, PH_NAME: begin
            if (dfr_phase == PH_CHAT) begin
               r.kind = K_CHAT;
               r.data_out = b;
            end else begin
               r.kind = K_NAME;
               // drop name bytes past the limit
               if (dfr_pos < NAME_LIMIT) r.data_out = b;
               else r.name_overflow = 1'b1;
            end
            dfr_pos = dfr_pos + 1'b1;
            if (dfr_pos >= {1'b0, dfr_len}) begin
               r.message_end = 1'b1;
               dfr_phase = PH_TYPE;
            end
         end
         PH_SIZE: begin
            r.kind = K_SIZE;
            r.data_out = b;
            dfr_frag = dfr_frag & 4'd7;
            if (dfr_frag == 0) dfr_acc = '0;
            dfr_acc = dfr_acc | ({56'd0, b} << (ACC_W - 8 * (int'(dfr_frag) + 1)));
            dfr_frag = dfr_frag + 1'b1;
            dfr_pos = dfr_pos + 1'b1;
            if (dfr_frag >= SIZE_MSG_LEN) begin
               dfr_frag = '0;
               r.size_ready = 1'b1;
               r.file_size_out = dfr_acc[FILE_SIZE_W-1:0];
               r.message_end = 1'b1;
               dfr_phase = PH_TYPE;
            end
         end
         PH_DATA: begin
            r.kind = K_DATA;
            r.data_out = b;
            dfr_total = dfr_total + 1'b1;
            dfr_pos = dfr_pos + 1'b1;
            // a negative size completes on every byte
            if (dfr_acc[63] || dfr_total >= dfr_acc) begin
               r.file_complete = 1'b1;
               dfr_total = '0;
               r.message_end = 1'b1;
               dfr_phase = PH_TYPE;
            end else if (dfr_pos >= {1'b0, dfr_len}) begin
               r.message_end = 1'b1;
               dfr_phase = PH_TYPE;
            end
         end
         default: to_error = 1'b1;
      endcase
      if (to_error) begin
         dfr_err = 1'b1;
         dfr_phase = PH_ERROR;
      end
      if (dfr_phase == PH_ERROR) begin
         r = '0;
         r.kind = K_ERROR;
      end
      r.error = dfr_err;
   endtask

   task automatic push_byte(input logic [7:0] b);
      pending_bytes.push_back(b);
      phase_pushed++;
   endtask

   task automatic push_header(input logic [7:0] t, input logic [15:0] len);
      push_byte(t);
      push_byte(len[15:8]);
      push_byte(len[7:0]);
   endtask

   // Build one well-formed message for type byte t. fill < 0 gives random payload.
   task automatic emit_message(input logic [7:0] t, input int len_req,
                               input logic [63:0] size_val, input int fill);
      logic [63:0] rem;
      int pad;
      case (meaning_of(t))
         K_SIZE: begin
            push_header(t, 16'(SIZE_MSG_LEN));
            for (int i = 7; i >= 0; i--) push_byte(size_val[8*i +: 8]);
            gen_size = size_val;
         end
         K_DATA: begin
            if (len_req == 0) begin
               push_header(t, 16'd0);
            end else begin
               if (gen_size[63] || gen_count + 1 >= gen_size) rem = 64'd1;
               else rem = gen_size - gen_count;
               if (rem <= 64'(len_req)) begin
                  // completion cuts the message; pad the rest with empty data headers
                  pad = $urandom_range(0, 2);
                  push_header(t, 16'(int'(rem) + 3 * pad));
                  for (int i = 0; i < int'(rem); i++)
                     push_byte((fill < 0) ? 8'($urandom) : fill[7:0]);
                  for (int i = 0; i < pad; i++) push_header(cfg.code_file_data, 16'd0);
                  gen_count = '0;
               end else begin
                  push_header(t, 16'(len_req));
                  for (int i = 0; i < len_req; i++)
                     push_byte((fill < 0) ? 8'($urandom) : fill[7:0]);
                  gen_count = gen_count + 64'(len_req);
               end
            end
         end
         default: begin
            push_header(t, 16'(len_req));
            for (int i = 0; i < len_req; i++)
               push_byte((fill < 0) ? 8'($urandom) : fill[7:0]);
         end
      endcase
   endtask

   task automatic fill_random(input int target);
      logic [7:0]  t;
      logic [63:0] size_val;
      int len;
      int sel;
      while (phase_pushed < target) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) t = cfg.code_file_data;
         else if (sel < 6) t = cfg.code_chat;
         else if (sel < 8) t = cfg.code_file_name;
         else t = cfg.code_file_size;
         case ($urandom_range(0, 9))
            0: size_val = 64'd0;
            1: size_val = {1'b1, 31'($urandom), 32'($urandom)};
            2: size_val = {1'b0, 31'($urandom), 32'($urandom)};
            default: size_val = 64'($urandom_range(1, 30));
         endcase
         if ($urandom_range(0, 9) == 0) len = 0;
         else if (meaning_of(t) == K_NAME) len = $urandom_range(1, 10);
         else len = $urandom_range(1, 12);
         emit_message(t, len, size_val, -1);
      end
   endtask

   task automatic write_code(input csr_index_type idx, input logic [7:0] v);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         CSR_CODE_FILE_DATA: cfg.code_file_data = v;
         CSR_CODE_FILE_NAME: cfg.code_file_name = v;
         CSR_CODE_FILE_SIZE: cfg.code_file_size = v;
         CSR_CODE_CHAT:      cfg.code_chat      = v;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained;
      while (pending_bytes.size() != 0 || req_if.valid || expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_all(input logic [7:0] d, input logic [7:0] n,
                            input logic [7:0] s, input logic [7:0] c);
      write_code(CSR_CODE_FILE_DATA, d);
      write_code(CSR_CODE_FILE_NAME, n);
      write_code(CSR_CODE_FILE_SIZE, s);
      write_code(CSR_CODE_CHAT, c);
   endtask

   // Sender: present the next pending byte after its drawn gap.
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_fire) begin
         // hold until accepted
      end else if (gap_left > 0) begin
         req_if.valid <= 1'b0;
         gap_left <= gap_left - 1;
      end else if (pending_bytes.size() > 0) begin
         req_if.byte_in <= pending_bytes.pop_front();
         req_if.valid <= 1'b1;
         gap_left <= idle_on ? $urandom_range(0, 18) : 0;
      end else begin
         req_if.valid <= 1'b0;
      end
   end

   // Receiver: per-item stall, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_done != hold_req) begin
         hold_done <= hold_req;
         hold_left <= LONG_HOLD;
         rsp_if.ready <= 1'b0;
      end else if (rsp_fire && idle_on) begin
         rsp_wait = $urandom_range(0, 18);
         if (rsp_wait > 0) begin
            rsp_if.ready <= 1'b0;
            rsp_wait = rsp_wait - 1;
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end else if (rsp_wait > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_wait = rsp_wait - 1;
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : byte_acceptor
      result_type next_result;
      req_fire <= !reset && req_if.valid && req_if.ready;
      if (!reset && req_if.valid && req_if.ready) begin
         deframe_byte(req_if.byte_in, next_result);
         expected_results.push_back(next_result);
      end
   end

   always @(posedge clock) begin : result_checker
      result_type got;
      result_type want;
      rsp_fire <= !reset && rsp_if.valid && rsp_if.ready;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.kind          = kind_type'(rsp_if.kind);
         got.data_out      = rsp_if.data_out;
         got.message_end   = rsp_if.message_end;
         got.file_complete = rsp_if.file_complete;
         got.size_ready    = rsp_if.size_ready;
         got.file_size_out = rsp_if.file_size_out;
         got.name_overflow = rsp_if.name_overflow;
         got.error         = rsp_if.error;
         if (expected_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: kind=%0d data=%02h", got.kind, got.data_out);
         end else begin
            want = expected_results.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("mismatch expected: kind=%0d data=%02h end=%0b done=%0b rdy=%0b size=%0h ovf=%0b err=%0b",
                           want.kind, want.data_out, want.message_end, want.file_complete,
                           want.size_ready, want.file_size_out, want.name_overflow, want.error);
                  $display("         actual:   kind=%0d data=%02h end=%0b done=%0b rdy=%0b size=%0h ovf=%0b err=%0b",
                           got.kind, got.data_out, got.message_end, got.file_complete,
                           got.size_ready, got.file_size_out, got.name_overflow, got.error);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      logic [7:0]  t;
      logic [15:0] bad_len;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.byte_in = '0;
      rsp_if.ready = 1'b0;
      cfg = '{RST_CODE_FILE_DATA, RST_CODE_FILE_NAME, RST_CODE_FILE_SIZE, RST_CODE_CHAT};
      dfr_phase = PH_TYPE;
      dfr_type = '0;
      dfr_len = '0;
      dfr_pos = '0;
      dfr_acc = '0;
      dfr_frag = '0;
      dfr_total = '0;
      dfr_err = 1'b0;
      gen_size = '0;
      gen_count = '0;
      idle_on = 1'b1;
      gap_left = 0;
      rsp_wait = 0;
      hold_left = 0;
      hold_req = 0;
      hold_done = 0;
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      mismatch_count = 0;
      cycle_count = 0;
      phase_pushed = 0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset codes: directed cases first, then random traffic behind a long receiver hold.
      emit_message(cfg.code_file_data, 1, 64'd0, 8'hFF);   // no size announced yet
      emit_message(cfg.code_chat, 0, 64'd0, -1);
      emit_message(cfg.code_chat, 1, 64'd0, 8'h00);
      emit_message(cfg.code_file_size, 8, 64'hFFFF_FFFF_FFFF_FFFF, -1);
      emit_message(cfg.code_file_data, 1, 64'd0, 8'h5A);   // negative size completes at once
      emit_message(cfg.code_file_name, 0, 64'd0, -1);
      hold_req++;
      fill_random(150);
      wait_drained;

      // Distinct codes, no idling, one name past the limit, then random traffic.
      idle_on = 1'b0;
      phase_pushed = 0;
      write_all(8'h41, 8'h42, 8'h43, 8'h44);
      emit_message(cfg.code_file_name, 256 + $urandom_range(0, 2), 64'd0, -1);
      fill_random(390);
      wait_drained;

      // All codes equal: every message is file data.
      idle_on = 1'b1;
      phase_pushed = 0;
      write_all(8'hFF, 8'hFF, 8'hFF, 8'hFF);
      fill_random(130);
      wait_drained;

      // Extreme code values, another oversized name.
      phase_pushed = 0;
      write_all(8'hFF, 8'h00, 8'h80, 8'h7F);
      emit_message(cfg.code_file_name, 256 + $urandom_range(0, 2), 64'd0, -1);
      fill_random(130);
      wait_drained;

      // Colliding random codes, long hold again.
      phase_pushed = 0;
      write_all(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
                8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)));
      hold_req++;
      fill_random(250);
      wait_drained;

      // Last: traffic, then drive into the sticky error and keep feeding noise.
      phase_pushed = 0;
      write_all(8'h10, 8'h20, 8'h30, 8'h40);
      fill_random(60);
      if ($urandom_range(0, 1) == 0) begin
         t = 8'($urandom);
         while (meaning_of(t) != K_ERROR) t = 8'($urandom);
         push_header(t, 16'($urandom));
      end else begin
         bad_len = 16'($urandom);
         if (bad_len == 16'(SIZE_MSG_LEN)) bad_len = 16'd9;
         push_header(cfg.code_file_size, bad_len);
      end
      for (int i = 0; i < 20; i++) push_byte(8'($urandom));
      wait_drained;
      repeat (4) @(posedge clock);

      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
